// ----- rtl/core/fhsfc_pkg.sv -----
// shared types and constants of the frame header, sum and footer checker
package fhsfc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_FOOTER_FIRST  = 2'd2,
    CFG_FOOTER_SECOND = 2'd3
  } cfg_idx_e;

  // frame status codes
  localparam logic STATUS_PASS = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             end_of_frame;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] footer_first;
    logic [ByteW-1:0] footer_second;
  } cfg_t;

endpackage

// ----- rtl/core/fhsfc_in_stage.sv -----
// input register stage holding one frame byte until the core consumes it
module fhsfc_in_stage
  import fhsfc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  input  logic  item_pop_i,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // free when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || item_pop_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (item_pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/core/fhsfc_core.sv -----
// per-frame state and the pass or fail decision on the final byte
module fhsfc_core
  import fhsfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output logic  status_o
);

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME_BYTES);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  len_q, len_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] rb0_q, rb1_q;
  logic             hdr_q, hdr_d;
  logic             ovf_q, ovf_d;

  logic [ByteW-1:0] b;
  logic             len_ge2;
  logic [PosW:0]    len_p2;
  logic             pos_ge4;
  logic             in_range;
  logic             fail;

  assign b       = item_i.frame_byte;
  assign len_ge2 = |len_q[PosW-1:1];
  assign len_p2  = {1'b0, len_q} + (PosW+1)'(2);
  assign pos_ge4 = |pos_q[PosW-1:2];
  assign in_range = pos_ge4 && len_ge2 && ({1'b0, pos_q} <= len_p2);

  always_comb begin
    ovf_d = ovf_q || (pos_q >= MaxPos);
    hdr_d = hdr_q;
    len_d = len_q;
    sum_d = sum_q;
    if (pos_q == PosW'(1)) begin
      hdr_d = (rb0_q == cfg_i.header_first) && (b == cfg_i.header_second);
    end else if (pos_q == PosW'(2)) begin
      len_d = {len_q[PosW-1:ByteW], b};
    end else if (pos_q == PosW'(3)) begin
      len_d = {b, len_q[ByteW-1:0]};
    end else if (in_range) begin
      sum_d = sum_q + b;
    end
  end

  // any failing check marks the frame invalid
  assign fail = ovf_d || !pos_ge4 || !hdr_d
             || (rb0_q != cfg_i.footer_first) || (b != cfg_i.footer_second)
             || (len_ge2 && (len_p2 > {1'b0, pos_q}))
             || (rb1_q != sum_d);

  assign status_o = fail ? STATUS_FAIL : STATUS_PASS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
      sum_q <= '0;
      rb0_q <= '0;
      rb1_q <= '0;
      hdr_q <= 1'b0;
      ovf_q <= 1'b0;
    end else if (step_i) begin
      if (item_i.end_of_frame) begin
        pos_q <= '0;
        len_q <= '0;
        sum_q <= '0;
        rb0_q <= '0;
        rb1_q <= '0;
        hdr_q <= 1'b0;
        ovf_q <= 1'b0;
      end else begin
        pos_q <= (&pos_q) ? pos_q : pos_q + PosW'(1);
        len_q <= len_d;
        sum_q <= sum_d;
        rb0_q <= b;
        rb1_q <= rb0_q;
        hdr_q <= hdr_d;
        ovf_q <= ovf_d;
      end
    end
  end

endmodule

// ----- rtl/core/frame_header_sum_footer_checker.sv -----
// top level of the frame header, additive sum and footer checker
//
//   channel   dir   handshake                        payload
//   s_axis    in    s_axis_tvalid / s_axis_tready    tdata[7:0] frame_byte, tlast end_of_frame
//   m_axis    out   m_axis_tvalid / m_axis_tready    tdata[0] frame_status, tdata[7:1] zero
//   cfg       in    cfg_valid_i / cfg_ready_o        cfg_index_i register, cfg_data_i value
//
// one byte per cycle while no final byte waits for the result register; the
// status of a frame is registered in the result register as its final byte
// leaves the input register; the per-frame state (position, length, sum, last
// two bytes) updates once per byte in the core, as each byte leaves that register
// reset clears the per-frame state, the configuration registers and both valids
// a final byte waits in the input register while the result register is full
// and not being drained, and the bytes behind it stall until the status drains
module frame_header_sum_footer_checker
  import fhsfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // frame bytes in
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,   // [7:0] frame_byte
  input  logic               s_axis_tlast,   // end_of_frame
  // frame status out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ByteW-1:0]   m_axis_tdata,   // [0] frame_status, [7:1] zero
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  item_pop;
  logic  out_free;
  logic  status;
  cfg_t  cfg_q;

  logic  out_valid_q, out_valid_d;
  logic  out_status_q;

  // configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_data_i;
        CFG_HEADER_SECOND: cfg_q.header_second <= cfg_data_i;
        CFG_FOOTER_FIRST:  cfg_q.footer_first  <= cfg_data_i;
        CFG_FOOTER_SECOND: cfg_q.footer_second <= cfg_data_i;
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  assign in_item.frame_byte   = s_axis_tdata;
  assign in_item.end_of_frame = s_axis_tlast;

  fhsfc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  // result register takes a new status when empty or being drained
  assign out_free = !out_valid_q || m_axis_tready;
  // non-final bytes always proceed, a final byte needs room for its status
  assign item_pop = item_valid && (!item.end_of_frame || out_free);

  fhsfc_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (item_pop),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (item_pop && item.end_of_frame) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop && item.end_of_frame) begin
      out_status_q <= status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ByteW-1){1'b0}}, out_status_q};

endmodule
